// ----- rtl/pft_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_pkg
// Shared types, widths, register indexes and helpers of the polygon
// fan and outline tessellator.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int MIN_POINTS     = 3;
    localparam int FAN_MAX        = 4;

    localparam int COORD_W = 16;
    localparam int RGBA_W  = 32;
    localparam int DLT_W   = 17;
    localparam int SQ_W    = 32;
    localparam int NRM_W   = 16;
    localparam int DEN_W   = 32;
    localparam int DIV_NW  = 45;
    localparam int DIV_DW  = 31;
    localparam int SQ_IW   = 62;
    localparam int SQ_RW   = 31;
    localparam int MIT_W   = 46;
    localparam int SCL_W   = 63;
    localparam int OFF_W   = 45;
    localparam int SUM_W   = 47;
    localparam int FRAC_SH = 28;
    localparam int WID_SH  = 18;
    localparam int CFG_AW  = 4;

    localparam logic signed [DEN_W-1:0] ONE_Q28 = 32'sd268435456;
    localparam logic signed [SCL_W-1:0] WID_RND = SCL_W'((64'd1 << WID_SH) - 64'd1);

    localparam logic [1:0] REG_FILL_EN    = 2'd0;
    localparam logic [1:0] REG_OUTLINE_EN = 2'd1;
    localparam logic [1:0] REG_OUTLINE_W  = 2'd2;

    localparam logic        FILL_EN_RST    = 1'b1;
    localparam logic        OUTLINE_EN_RST = 1'b0;
    localparam logic [15:0] OUTLINE_W_RST  = 16'd256;

    localparam logic KIND_FILL    = 1'b0;
    localparam logic KIND_OUTLINE = 1'b1;

    typedef struct packed {
        logic [RGBA_W-1:0]  edge_rgba;
        logic [RGBA_W-1:0]  fill_rgba;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } point_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [SQ_IW-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic             done;
        logic [SQ_RW-1:0] root;
    } sqrt_rsp_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CDIV_GO,
        ST_CDIV_WAIT,
        ST_FILL_CTR,
        ST_FILL_RD,
        ST_FILL_EMIT,
        ST_OL_RDP,
        ST_OL_RDA,
        ST_OL_RDB,
        ST_OL_LATB,
        ST_NRM_SQ,
        ST_NRM_SQRT_GO,
        ST_NRM_SQRT_WAIT,
        ST_NRM_DX_GO,
        ST_NRM_DX_WAIT,
        ST_NRM_DY_GO,
        ST_NRM_DY_WAIT,
        ST_NRM_DONE,
        ST_MIT_MUL,
        ST_MIT_DEN,
        ST_MIT_CHK,
        ST_MIT_DX_GO,
        ST_MIT_DX_WAIT,
        ST_MIT_DY_GO,
        ST_MIT_DY_WAIT,
        ST_SIGN,
        ST_SCALE,
        ST_SHIFT,
        ST_EMIT_P,
        ST_EMIT_O,
        ST_EMIT_F0,
        ST_EMIT_F1
    } seq_state_t;

    function automatic logic [COORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(32767);
        lo = -SUM_W'(32768);
        if (v > hi)
        begin
            return hi[COORD_W-1:0];
        end
        else if (v < lo)
        begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ----- rtl/polygon_fan_and_outline_tessellator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_fan_and_outline_tessellator_top
// Loads polygon points into a point memory and tessellates each polygon
// into fill fan and outline strip vertices.
// ----------------------------------------------------------------------------
// Points arrive on the s_ stream, one per transfer; s_tlast marks the last
// point of a polygon. Vertices leave on the m_ stream; m_tuser tells fill
// from outline vertices and m_tlast marks the last vertex of a polygon.
// Registers are to be written through the APB port only while the block
// is idle; the block itself does not enforce this. Points that do not end
// a polygon are taken back to back. A last point that brings the count to
// three or more, with fill or outline enabled, ends the load state: the
// block works out the centroid and average color with six serial divisions,
// streams the fill vertices if fill is on and the outline points if outline
// is on, with up to six quotients and two square roots per outline point.
// s_tready is high only in the load state. Vertices pass through one output
// register, so a stalled receiver holds the sequencer at its next vertex;
// the block returns to loading as soon as the last vertex is registered.
// Reset empties the point count and sums and restores the register
// defaults; the point memory keeps no reset state.
// ----------------------------------------------------------------------------
module polygon_fan_and_outline_tessellator_top #(
    parameter int MAX_POINTS = pft_pkg::MAX_POINTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [95:0]               s_tdata,   // pos_x, pos_y, fill_rgba, edge_rgba
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,   // vert_x, vert_y, vert_rgba
    output logic                      m_tuser,   // prim_kind
    output logic                      m_tlast,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pft_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import pft_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SXW = COORD_W + CW;
    localparam int SCW = 8 + CW;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic                    fill_en_reg;
    logic                    outline_en_reg;
    logic [15:0]             outline_w_reg;

    logic [CW-1:0]           cnt_reg;
    logic signed [SXW-1:0]   sum_x_reg;
    logic signed [SXW-1:0]   sum_y_reg;
    logic [SCW-1:0]          sum_c_reg [4];

    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic [RGBA_W-1:0]       ccol_reg;
    logic [2:0]              csel_reg;
    logic [CW-1:0]           j_reg;
    logic                    which_reg;

    point_t                  p_reg;
    point_t                  a_reg;
    point_t                  b_reg;
    logic signed [DLT_W-1:0] dx_reg;
    logic signed [DLT_W-1:0] dy_reg;
    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         sqy_reg;
    logic [SQ_RW-1:0]        len_reg;
    logic signed [NRM_W-1:0] n1x_reg;
    logic signed [NRM_W-1:0] n1y_reg;
    logic signed [NRM_W-1:0] n2x_reg;
    logic signed [NRM_W-1:0] n2y_reg;
    logic signed [DEN_W-1:0] prod1_reg;
    logic signed [DEN_W-1:0] prod2_reg;
    logic signed [DEN_W-1:0] den_reg;
    logic signed [DLT_W-1:0] sx_reg;
    logic signed [DLT_W-1:0] sy_reg;
    logic signed [MIT_W-1:0] mx_reg;
    logic signed [MIT_W-1:0] my_reg;
    logic signed [SCL_W-1:0] scx_reg;
    logic signed [SCL_W-1:0] scy_reg;
    logic signed [OFF_W-1:0] offx_reg;
    logic signed [OFF_W-1:0] offy_reg;

    logic [COORD_W-1:0]      f_px_reg;
    logic [COORD_W-1:0]      f_py_reg;
    logic [COORD_W-1:0]      f_ox_reg;
    logic [COORD_W-1:0]      f_oy_reg;
    logic [RGBA_W-1:0]       f_col_reg;

    logic                    m_valid_reg;
    logic [COORD_W-1:0]      m_x_reg;
    logic [COORD_W-1:0]      m_y_reg;
    logic [RGBA_W-1:0]       m_col_reg;
    logic                    m_kind_reg;
    logic                    m_last_reg;

    point_t                  in_pt;
    point_t                  rdata;
    logic                    s_fire;
    logic                    full_w;
    logic [CW-1:0]           n_new_w;
    logic                    go_w;
    logic [CW-1:0]           lim_w;
    logic [CW-1:0]           prev_w;
    logic [CW-1:0]           next_w;
    logic                    out_free;
    logic                    seq_end;
    logic                    mem_re;
    logic [CW-1:0]           mem_raddr;
    div_req_t                div_req;
    div_rsp_t                div_rsp;
    sqrt_req_t               sqrt_req;
    sqrt_rsp_t               sqrt_rsp;
    logic                    emit;
    logic [COORD_W-1:0]      e_x;
    logic [COORD_W-1:0]      e_y;
    logic [RGBA_W-1:0]       e_col;
    logic                    e_kind;
    logic                    e_last;

    logic [SXW-1:0]          cmag_x;
    logic [SXW-1:0]          cmag_y;
    logic [DIV_NW-1:0]       cdiv_num;
    logic                    cdiv_neg;
    logic [DLT_W-1:0]        dx_mag;
    logic [DLT_W-1:0]        dy_mag;
    logic [DLT_W-1:0]        sx_mag;
    logic [DLT_W-1:0]        sy_mag;
    logic signed [DLT_W-1:0] pd_w;
    logic signed [SCL_W-1:0] scx_adj;
    logic signed [SCL_W-1:0] scy_adj;
    logic [COORD_W-1:0]      ox_w;
    logic [COORD_W-1:0]      oy_w;
    logic                    cfg_we;
    logic [SXW-1:0]          cq_w;

    // Configuration registers.
    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_en_reg    <= FILL_EN_RST;
            outline_en_reg <= OUTLINE_EN_RST;
            outline_w_reg  <= OUTLINE_W_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_FILL_EN:    fill_en_reg    <= pwdata[0];
                REG_OUTLINE_EN: outline_en_reg <= pwdata[0];
                REG_OUTLINE_W:  outline_w_reg  <= pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FILL_EN:    prdata = {31'd0, fill_en_reg};
            REG_OUTLINE_EN: prdata = {31'd0, outline_en_reg};
            REG_OUTLINE_W:  prdata = {16'd0, outline_w_reg};
            default:        prdata = '0;
        endcase
    end

    // Point store and arithmetic units.
    assign in_pt  = point_t'(s_tdata);
    assign s_fire = s_tvalid && s_tready;
    assign full_w = cnt_reg == CW'(MAX_POINTS);

    pft_point_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (s_fire && !full_w),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (in_pt),
        .re    (mem_re),
        .raddr (mem_raddr[AW-1:0]),
        .rdata (rdata)
    );

    pft_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pft_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // Datapath helpers.
    always_comb
    begin
        n_new_w = cnt_reg + CW'(!full_w);
        go_w    = (n_new_w >= CW'(MIN_POINTS)) && (fill_en_reg || outline_en_reg);
        lim_w   = (cnt_reg > CW'(FAN_MAX)) ? cnt_reg : cnt_reg - 1'b1;
        prev_w  = (j_reg == '0) ? cnt_reg - 1'b1 : j_reg - 1'b1;
        next_w  = (j_reg == cnt_reg - 1'b1) ? '0 : j_reg + 1'b1;
        cmag_x  = sum_x_reg[SXW-1] ? SXW'(-sum_x_reg) : SXW'(sum_x_reg);
        cmag_y  = sum_y_reg[SXW-1] ? SXW'(-sum_y_reg) : SXW'(sum_y_reg);
        case (csel_reg)
            3'd0:    begin cdiv_num = DIV_NW'(cmag_x); cdiv_neg = sum_x_reg[SXW-1]; end
            3'd1:    begin cdiv_num = DIV_NW'(cmag_y); cdiv_neg = sum_y_reg[SXW-1]; end
            3'd2:    begin cdiv_num = DIV_NW'(sum_c_reg[0]); cdiv_neg = 1'b0; end
            3'd3:    begin cdiv_num = DIV_NW'(sum_c_reg[1]); cdiv_neg = 1'b0; end
            3'd4:    begin cdiv_num = DIV_NW'(sum_c_reg[2]); cdiv_neg = 1'b0; end
            default: begin cdiv_num = DIV_NW'(sum_c_reg[3]); cdiv_neg = 1'b0; end
        endcase
        cq_w    = div_rsp.quo[SXW-1:0];
        dx_mag  = dx_reg[DLT_W-1] ? DLT_W'(-dx_reg) : DLT_W'(dx_reg);
        dy_mag  = dy_reg[DLT_W-1] ? DLT_W'(-dy_reg) : DLT_W'(dy_reg);
        sx_mag  = sx_reg[DLT_W-1] ? DLT_W'(-sx_reg) : DLT_W'(sx_reg);
        sy_mag  = sy_reg[DLT_W-1] ? DLT_W'(-sy_reg) : DLT_W'(sy_reg);
        pd_w    = DLT_W'($signed(p_reg.pos_x)) - DLT_W'(cx_reg);
        scx_adj = scx_reg[SCL_W-1] ? scx_reg + WID_RND : scx_reg;
        scy_adj = scy_reg[SCL_W-1] ? scy_reg + WID_RND : scy_reg;
        ox_w    = sat16(SUM_W'($signed(p_reg.pos_x)) + SUM_W'(offx_reg));
        oy_w    = sat16(SUM_W'($signed(p_reg.pos_y)) + SUM_W'(offy_reg));
        out_free = !m_valid_reg || m_tready;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (s_fire && s_tlast && go_w)
                begin
                    state_next = ST_CDIV_GO;
                end
            end
            ST_CDIV_GO:
            begin
                state_next = ST_CDIV_WAIT;
            end
            ST_CDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (csel_reg != 3'd5)
                    begin
                        state_next = ST_CDIV_GO;
                    end
                    else if (fill_en_reg)
                    begin
                        state_next = (cnt_reg > CW'(FAN_MAX)) ? ST_FILL_CTR : ST_FILL_RD;
                    end
                    else
                    begin
                        state_next = ST_OL_RDP;
                    end
                end
            end
            ST_FILL_CTR:
            begin
                if (out_free)
                begin
                    state_next = ST_FILL_RD;
                end
            end
            ST_FILL_RD:
            begin
                state_next = ST_FILL_EMIT;
            end
            ST_FILL_EMIT:
            begin
                if (out_free)
                begin
                    if (j_reg != lim_w)
                    begin
                        state_next = ST_FILL_RD;
                    end
                    else
                    begin
                        state_next = outline_en_reg ? ST_OL_RDP : ST_LOAD;
                    end
                end
            end
            ST_OL_RDP:        state_next = ST_OL_RDA;
            ST_OL_RDA:        state_next = ST_OL_RDB;
            ST_OL_RDB:        state_next = ST_OL_LATB;
            ST_OL_LATB:       state_next = ST_NRM_SQ;
            ST_NRM_SQ:        state_next = ST_NRM_SQRT_GO;
            ST_NRM_SQRT_GO:   state_next = ST_NRM_SQRT_WAIT;
            ST_NRM_SQRT_WAIT:
            begin
                if (sqrt_rsp.done)
                begin
                    state_next = (sqrt_rsp.root == '0) ? ST_NRM_DONE : ST_NRM_DX_GO;
                end
            end
            ST_NRM_DX_GO:     state_next = ST_NRM_DX_WAIT;
            ST_NRM_DX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_NRM_DY_GO;
                end
            end
            ST_NRM_DY_GO:     state_next = ST_NRM_DY_WAIT;
            ST_NRM_DY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_NRM_DONE;
                end
            end
            ST_NRM_DONE:      state_next = which_reg ? ST_MIT_MUL : ST_NRM_SQ;
            ST_MIT_MUL:       state_next = ST_MIT_DEN;
            ST_MIT_DEN:       state_next = ST_MIT_CHK;
            ST_MIT_CHK:       state_next = (den_reg > 0) ? ST_MIT_DX_GO : ST_SIGN;
            ST_MIT_DX_GO:     state_next = ST_MIT_DX_WAIT;
            ST_MIT_DX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MIT_DY_GO;
                end
            end
            ST_MIT_DY_GO:     state_next = ST_MIT_DY_WAIT;
            ST_MIT_DY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:          state_next = ST_SCALE;
            ST_SCALE:         state_next = ST_SHIFT;
            ST_SHIFT:         state_next = ST_EMIT_P;
            ST_EMIT_P:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT_O;
                end
            end
            ST_EMIT_O:
            begin
                if (out_free)
                begin
                    state_next = (j_reg == cnt_reg - 1'b1) ? ST_EMIT_F0 : ST_OL_RDP;
                end
            end
            ST_EMIT_F0:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT_F1;
                end
            end
            ST_EMIT_F1:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:          state_next = ST_LOAD;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready          = 1'b0;
        mem_re            = 1'b0;
        mem_raddr         = j_reg;
        div_req.start     = 1'b0;
        div_req.num       = cdiv_num;
        div_req.den       = DIV_DW'(cnt_reg);
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = SQ_IW'(SQ_W'(sqx_reg) + (SQ_W + 1)'(sqy_reg)) << FRAC_SH;
        emit              = 1'b0;
        e_x               = p_reg.pos_x;
        e_y               = p_reg.pos_y;
        e_col             = p_reg.edge_rgba;
        e_kind            = KIND_OUTLINE;
        e_last            = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
            end
            ST_CDIV_GO:
            begin
                div_req.start = 1'b1;
            end
            ST_FILL_CTR:
            begin
                emit   = out_free;
                e_x    = cx_reg;
                e_y    = cy_reg;
                e_col  = ccol_reg;
                e_kind = KIND_FILL;
            end
            ST_FILL_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = (j_reg == cnt_reg) ? '0 : j_reg;
            end
            ST_FILL_EMIT:
            begin
                emit   = out_free;
                e_x    = rdata.pos_x;
                e_y    = rdata.pos_y;
                e_col  = rdata.fill_rgba;
                e_kind = KIND_FILL;
                e_last = (j_reg == lim_w) && !outline_en_reg;
            end
            ST_OL_RDP:
            begin
                mem_re = 1'b1;
            end
            ST_OL_RDA:
            begin
                mem_re    = 1'b1;
                mem_raddr = prev_w;
            end
            ST_OL_RDB:
            begin
                mem_re    = 1'b1;
                mem_raddr = next_w;
            end
            ST_NRM_SQRT_GO:
            begin
                sqrt_req.start = 1'b1;
            end
            ST_NRM_DX_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(dy_mag) << FRAC_SH;
                div_req.den   = len_reg;
            end
            ST_NRM_DY_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(dx_mag) << FRAC_SH;
                div_req.den   = len_reg;
            end
            ST_MIT_DX_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(sx_mag) << FRAC_SH;
                div_req.den   = den_reg[DIV_DW-1:0];
            end
            ST_MIT_DY_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(sy_mag) << FRAC_SH;
                div_req.den   = den_reg[DIV_DW-1:0];
            end
            ST_EMIT_P:
            begin
                emit = out_free;
            end
            ST_EMIT_O:
            begin
                emit = out_free;
                e_x  = ox_w;
                e_y  = oy_w;
            end
            ST_EMIT_F0:
            begin
                emit  = out_free;
                e_x   = f_px_reg;
                e_y   = f_py_reg;
                e_col = f_col_reg;
            end
            ST_EMIT_F1:
            begin
                emit   = out_free;
                e_x    = f_ox_reg;
                e_y    = f_oy_reg;
                e_col  = f_col_reg;
                e_last = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign seq_end = (state_reg != ST_LOAD) && (state_next == ST_LOAD);

    // Control state: sequencer, point count and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            for (int c = 0; c < 4; c++)
            begin
                sum_c_reg[c] <= '0;
            end
            csel_reg  <= '0;
            j_reg     <= '0;
            which_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (seq_end || (s_fire && s_tlast && !go_w))
            begin
                cnt_reg   <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                for (int c = 0; c < 4; c++)
                begin
                    sum_c_reg[c] <= '0;
                end
            end
            else if (s_fire && !full_w)
            begin
                cnt_reg   <= cnt_reg + 1'b1;
                sum_x_reg <= sum_x_reg + SXW'($signed(in_pt.pos_x));
                sum_y_reg <= sum_y_reg + SXW'($signed(in_pt.pos_y));
                for (int c = 0; c < 4; c++)
                begin
                    sum_c_reg[c] <= sum_c_reg[c] + SCW'(in_pt.fill_rgba[8*c +: 8]);
                end
            end
            if (s_fire)
            begin
                csel_reg <= '0;
                j_reg    <= '0;
            end
            if ((state_reg == ST_CDIV_WAIT) && div_rsp.done)
            begin
                csel_reg <= csel_reg + 1'b1;
            end
            if ((state_reg == ST_FILL_EMIT) && out_free)
            begin
                j_reg <= (j_reg == lim_w) ? '0 : j_reg + 1'b1;
            end
            if ((state_reg == ST_EMIT_O) && out_free)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (state_reg == ST_OL_RDP)
            begin
                which_reg <= 1'b0;
            end
            if (state_reg == ST_NRM_DONE)
            begin
                which_reg <= 1'b1;
            end
        end
    end

    // Arithmetic datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_CDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (csel_reg)
                        3'd0:    cx_reg <= cdiv_neg ? -COORD_W'(cq_w) : COORD_W'(cq_w);
                        3'd1:    cy_reg <= cdiv_neg ? -COORD_W'(cq_w) : COORD_W'(cq_w);
                        3'd2:    ccol_reg[7:0]   <= cq_w[7:0];
                        3'd3:    ccol_reg[15:8]  <= cq_w[7:0];
                        3'd4:    ccol_reg[23:16] <= cq_w[7:0];
                        default: ccol_reg[31:24] <= cq_w[7:0];
                    endcase
                end
            end
            ST_OL_RDA:
            begin
                p_reg <= rdata;
            end
            ST_OL_RDB:
            begin
                a_reg <= rdata;
            end
            ST_OL_LATB:
            begin
                b_reg  <= rdata;
                dx_reg <= DLT_W'($signed(a_reg.pos_x)) - DLT_W'($signed(p_reg.pos_x));
                dy_reg <= DLT_W'($signed(a_reg.pos_y)) - DLT_W'($signed(p_reg.pos_y));
            end
            ST_NRM_SQ:
            begin
                sqx_reg <= SQ_W'(dx_reg * dx_reg);
                sqy_reg <= SQ_W'(dy_reg * dy_reg);
            end
            ST_NRM_SQRT_WAIT:
            begin
                if (sqrt_rsp.done)
                begin
                    len_reg <= sqrt_rsp.root;
                    if (sqrt_rsp.root == '0)
                    begin
                        if (which_reg)
                        begin
                            n2x_reg <= '0;
                            n2y_reg <= '0;
                        end
                        else
                        begin
                            n1x_reg <= '0;
                            n1y_reg <= '0;
                        end
                    end
                end
            end
            ST_NRM_DX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (which_reg)
                    begin
                        n2x_reg <= dy_reg[DLT_W-1] ? -NRM_W'(div_rsp.quo) : NRM_W'(div_rsp.quo);
                    end
                    else
                    begin
                        n1x_reg <= dy_reg[DLT_W-1] ? -NRM_W'(div_rsp.quo) : NRM_W'(div_rsp.quo);
                    end
                end
            end
            ST_NRM_DY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (which_reg)
                    begin
                        n2y_reg <= dx_reg[DLT_W-1] ? NRM_W'(div_rsp.quo) : -NRM_W'(div_rsp.quo);
                    end
                    else
                    begin
                        n1y_reg <= dx_reg[DLT_W-1] ? NRM_W'(div_rsp.quo) : -NRM_W'(div_rsp.quo);
                    end
                end
            end
            ST_NRM_DONE:
            begin
                dx_reg <= DLT_W'($signed(p_reg.pos_x)) - DLT_W'($signed(b_reg.pos_x));
                dy_reg <= DLT_W'($signed(p_reg.pos_y)) - DLT_W'($signed(b_reg.pos_y));
            end
            ST_MIT_MUL:
            begin
                prod1_reg <= DEN_W'(n1x_reg * n2x_reg);
                prod2_reg <= DEN_W'(n1y_reg * n2y_reg);
                sx_reg    <= DLT_W'(n1x_reg) + DLT_W'(n2x_reg);
                sy_reg    <= DLT_W'(n1y_reg) + DLT_W'(n2y_reg);
            end
            ST_MIT_DEN:
            begin
                den_reg <= ONE_Q28 + prod1_reg + prod2_reg;
            end
            ST_MIT_CHK:
            begin
                mx_reg <= '0;
                my_reg <= '0;
            end
            ST_MIT_DX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mx_reg <= sx_reg[DLT_W-1] ? -$signed({1'b0, div_rsp.quo})
                                              : $signed({1'b0, div_rsp.quo});
                end
            end
            ST_MIT_DY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    my_reg <= sy_reg[DLT_W-1] ? -$signed({1'b0, div_rsp.quo})
                                              : $signed({1'b0, div_rsp.quo});
                end
            end
            ST_SIGN:
            begin
                if ((mx_reg == '0) || (pd_w == '0) || (mx_reg[MIT_W-1] != pd_w[DLT_W-1]))
                begin
                    mx_reg <= -mx_reg;
                end
            end
            ST_SCALE:
            begin
                scx_reg <= SCL_W'(mx_reg * $signed({1'b0, outline_w_reg}));
                scy_reg <= SCL_W'(my_reg * $signed({1'b0, outline_w_reg}));
            end
            ST_SHIFT:
            begin
                offx_reg <= OFF_W'(scx_adj >>> WID_SH);
                offy_reg <= OFF_W'(scy_adj >>> WID_SH);
            end
            ST_EMIT_P:
            begin
                if (j_reg == '0)
                begin
                    f_px_reg  <= p_reg.pos_x;
                    f_py_reg  <= p_reg.pos_y;
                    f_col_reg <= p_reg.edge_rgba;
                end
            end
            ST_EMIT_O:
            begin
                if (j_reg == '0)
                begin
                    f_ox_reg <= ox_w;
                    f_oy_reg <= oy_w;
                end
            end
            default:
            begin
                len_reg <= len_reg;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_x_reg    <= e_x;
            m_y_reg    <= e_y;
            m_col_reg  <= e_col;
            m_kind_reg <= e_kind;
            m_last_reg <= e_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_col_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/pft_point_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_point_mem
// Point store of one polygon: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module pft_point_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic           clk,
    input  logic           we,
    input  logic [AW-1:0]  waddr,
    input  pft_pkg::point_t wdata,
    input  logic           re,
    input  logic [AW-1:0]  raddr,
    output pft_pkg::point_t rdata
);
    import pft_pkg::*;

    point_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/pft_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_divider
// Serial restoring divider for unsigned operands, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module pft_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  pft_pkg::div_req_t   req,
    output pft_pkg::div_rsp_t   rsp
);
    import pft_pkg::*;

    localparam int CNT_W = $clog2(DIV_NW);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DIV_NW-1]};
        fits   = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
            rem_reg <= fits ? DIV_DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DW-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ----- rtl/pft_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_isqrt
// Serial integer square root, one root bit per cycle, result rounded down.
// ----------------------------------------------------------------------------
module pft_isqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pft_pkg::sqrt_req_t   req,
    output pft_pkg::sqrt_rsp_t   rsp
);
    import pft_pkg::*;

    localparam int CNT_W = $clog2(SQ_RW);
    localparam int REM_W = SQ_RW + 2;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SQ_IW-1:0]  opd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [SQ_RW-1:0]  root_reg;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              fits;

    always_comb
    begin
        rem_sh = {rem_reg, opd_reg[SQ_IW-1:SQ_IW-2]};
        trial  = (REM_W + 2)'({root_reg, 2'b01});
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            opd_reg  <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            opd_reg  <= {opd_reg[SQ_IW-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[SQ_RW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

// ----- rtl/pft_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pft_checker
// Port-level checks of the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module pft_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    import pft_pkg::*;

    logic outline_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outline_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            outline_seen_reg <= !m_tlast && (m_tuser == KIND_OUTLINE);
        end
    end

    // A stalled vertex holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("vertex changed while stalled");

    // Within one polygon no fill vertex follows an outline vertex.
    a_fill_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tuser == KIND_FILL) |-> !outline_seen_reg)
        else $error("fill vertex after outline vertex");

    // While a polygon is still being emitted no point is taken.
    a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready during tessellation");

endmodule

bind polygon_fan_and_outline_tessellator_top pft_checker u_pft_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
